[rtl/core/fbu_pkg.sv]
// Package for the fixed-width bit unpacker: widths, reset value of the width
// register, controller states and the command and status structs.
// No dependencies.
`default_nettype none

package fbu_pkg;

	localparam int WORD_W = 32;
	localparam int VBITS_W = 6;
	localparam int CNT_W = 6;
	localparam int ACC_W = 64;
	localparam int LEFT_W = 31;
	localparam int LCNT_W = 5;
	localparam int NVAL_W = 5;

	localparam logic [VBITS_W-1:0] VBITS_RESET = 6'd16;
	localparam logic [VBITS_W-1:0] VBITS_MAX = 6'd32;
	localparam logic [NVAL_W-1:0] NVAL_LAST = 5'd31;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} fbu_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
		logic clear;
	} fbu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
		logic out_free;
	} fbu_status_t;

	// A width of zero counts as one, anything above 32 counts as 32.
	function automatic logic [CNT_W-1:0] eff_width(input logic [VBITS_W-1:0] vb);
		logic [CNT_W-1:0] w;
		if (vb == '0) begin
			w = 6'd1;
		end else if (vb > VBITS_MAX) begin
			w = VBITS_MAX;
		end else begin
			w = vb;
		end
		return w;
	endfunction

endpackage

`default_nettype wire

[rtl/core/fbu_if.sv]
// Valid/ready channel interfaces for the fixed-width bit unpacker: packed
// words in, unpacked values out, and the width register write channel.
// Depends on fbu_pkg.
`default_nettype none

interface fbu_word_if;
	import fbu_pkg::*;
	logic valid;
	logic ready;
	logic [WORD_W-1:0] packed_word;
	modport source (output valid, output packed_word, input ready);
	modport sink (input valid, input packed_word, output ready);
endinterface

interface fbu_value_if;
	import fbu_pkg::*;
	logic valid;
	logic ready;
	logic [WORD_W-1:0] value;
	logic block_last;
	logic run_last;
	modport source (output valid, output value, output block_last, output run_last,
		input ready);
	modport sink (input valid, input value, input block_last, input run_last,
		output ready);
endinterface

interface fbu_cfg_if;
	import fbu_pkg::*;
	logic valid;
	logic ready;
	logic [VBITS_W-1:0] value_bits;
	modport source (output valid, output value_bits, input ready);
	modport sink (input valid, input value_bits, output ready);
endinterface

`default_nettype wire

[rtl/core/fbu_dp.sv]
// Datapath of the fixed-width bit unpacker: bit accumulator, extraction of one
// value per cycle when not stalled, value counter, width and output registers.
// Depends on fbu_pkg; driven by fbu_ctrl through command and status structs.
`default_nettype none

module fbu_dp #(
	parameter int BLOCK_VALUES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire fbu_pkg::fbu_cmd_t cmd,
	output fbu_pkg::fbu_status_t st,
	input wire logic [fbu_pkg::WORD_W-1:0] packed_word,
	input wire logic [fbu_pkg::VBITS_W-1:0] cfg_value_bits,
	input wire logic out_ready,
	output logic out_valid,
	output logic [fbu_pkg::WORD_W-1:0] value,
	output logic block_last,
	output logic run_last
);
	import fbu_pkg::*;

	localparam int IDX_W = (BLOCK_VALUES > 1) ? $clog2(BLOCK_VALUES) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_VALUES - 1);

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] total_q;
	logic [NVAL_W-1:0] nval_q;
	logic [IDX_W-1:0] idx_q;
	logic [VBITS_W-1:0] vbits_q;
	logic out_valid_q;
	logic [WORD_W-1:0] value_q;
	logic block_last_q;
	logic run_last_q;

	logic [CNT_W-1:0] width;
	logic [CNT_W-1:0] rem;
	logic [ACC_W-1:0] shifted;
	logic [WORD_W-1:0] mask;
	logic last;
	logic [LEFT_W-1:0] base_bits;
	logic [LCNT_W-1:0] base_cnt;
	logic [ACC_W-1:0] loaded;

	assign width = eff_width(vbits_q);
	assign rem = total_q - width;
	assign shifted = acc_q >> width;
	assign mask = ~({WORD_W{1'b1}} << width);
	// The value being extracted is the last of its word when what remains cannot
	// hold another one, or when the per-word limit of 32 values is reached.
	assign last = (rem < width) || (nval_q == NVAL_LAST);

	// A new word lands on top of the leftover bits: either those already held
	// or those that remain after the value extracted in this same cycle.
	assign base_bits = cmd.emit ? shifted[LEFT_W-1:0] : acc_q[LEFT_W-1:0];
	assign base_cnt = cmd.emit ? rem[LCNT_W-1:0] : total_q[LCNT_W-1:0];
	assign loaded = {{(ACC_W-LEFT_W){1'b0}}, base_bits}
		| ({{(ACC_W-WORD_W){1'b0}}, packed_word} << base_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			total_q <= '0;
			nval_q <= '0;
			idx_q <= '0;
			vbits_q <= VBITS_RESET;
		end else if (cmd.clear) begin
			acc_q <= '0;
			total_q <= '0;
			nval_q <= '0;
			idx_q <= '0;
			vbits_q <= cfg_value_bits;
		end else begin
			if (cmd.load) begin
				acc_q <= loaded;
				total_q <= CNT_W'(base_cnt) + CNT_W'(WORD_W);
				nval_q <= '0;
			end else if (cmd.emit) begin
				if (last) begin
					acc_q <= {{(ACC_W-LEFT_W){1'b0}}, shifted[LEFT_W-1:0]};
					total_q <= {1'b0, rem[LCNT_W-1:0]};
				end else begin
					acc_q <= shifted;
					total_q <= rem;
				end
				nval_q <= nval_q + 1'b1;
			end
			if (cmd.emit) begin
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= acc_q[WORD_W-1:0] & mask;
			block_last_q <= (idx_q == IDX_LAST);
			run_last_q <= last;
		end
	end

	assign st.last = last;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign block_last = block_last_q;
	assign run_last = run_last_q;

endmodule

`default_nettype wire

[rtl/core/fbu_ctrl.sv]
// Controller of the fixed-width bit unpacker: decides when a word is taken,
// when a value is extracted, and when the width register is written.
// Depends on fbu_pkg; drives fbu_dp through command and status structs.
`default_nettype none

module fbu_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic word_valid,
	output logic word_ready,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire fbu_pkg::fbu_status_t st,
	output fbu_pkg::fbu_cmd_t cmd,
	output fbu_pkg::fbu_state_t state
);
	import fbu_pkg::*;

	fbu_state_t state_q;
	fbu_state_t state_next;
	logic emit;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (word_valid) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit && st.last && !word_valid) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		word_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				word_ready = 1'b1;
			end
			ST_EMIT: begin
				emit = st.out_free;
				word_ready = st.out_free && st.last;
			end
			default: begin
				emit = 1'b0;
				word_ready = 1'b0;
			end
		endcase
	end

	assign take = word_valid && word_ready;
	assign cfg_ready = 1'b1;
	assign cmd.load = take;
	assign cmd.emit = emit;
	assign cmd.clear = cfg_valid;
	assign state = state_q;

endmodule

`default_nettype wire

[rtl/core/fixed_width_bit_unpacker.sv]
// Top level of the fixed-width bit unpacker: joins controller and datapath
// to the word, value and configuration channels.
// Depends on fbu_pkg, fbu_if, fbu_ctrl and fbu_dp.
//
// Usage. Packed 32-bit words arrive on word_ch, bit 0 of the stream first.
// Every value in the stream is value_bits wide (1 to 32), and a value may
// straddle two words. For each word the block returns on value_ch every value
// that the word completes, lowest bits first, zero-extended to 32 bits.
// run_last marks the last value produced for a word, and block_last marks the
// final value of each block of BLOCK_VALUES values.
// Timing. A taken word is loaded into the accumulator, the controller enters
// its extraction state, and each extracted value is registered in the output
// register. The block extracts one value per cycle while the output register
// is free, limited by the single extraction shifter. The next word is taken
// in the cycle that extracts the last value of the current one, so there is
// no gap between words.
// Stalls. The output register holds one value; while the receiver keeps ready
// low, extraction pauses. An idle block still takes one more word while its
// last value waits, and after that word_ch stays not ready.
// Reset. After arst_n the width is 16 and no bits are held. A transfer on
// cfg_ch, which is always ready, sets the width and starts a new stream:
// held bits and the value counter are discarded. Write it only while idle.
`default_nettype none

module fixed_width_bit_unpacker #(
	parameter int BLOCK_VALUES = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	fbu_word_if.sink word_ch,
	fbu_value_if.source value_ch,
	fbu_cfg_if.sink cfg_ch
);
	import fbu_pkg::*;

	fbu_cmd_t cmd;
	fbu_status_t st;
	fbu_state_t state;

	// The controller owns all handshake decisions.
	fbu_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(word_ch.valid),
		.word_ready(word_ch.ready),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.st(st),
		.cmd(cmd),
		.state(state)
	);

	// The datapath holds the bits and drives the output register.
	fbu_dp #(
		.BLOCK_VALUES(BLOCK_VALUES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.packed_word(word_ch.packed_word),
		.cfg_value_bits(cfg_ch.value_bits),
		.out_ready(value_ch.ready),
		.out_valid(value_ch.valid),
		.value(value_ch.value),
		.block_last(value_ch.block_last),
		.run_last(value_ch.run_last)
	);

	// Values are only extracted when the output register can take them.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> st.out_free)
		else $error("value extracted while output register is blocked");

	// A taken word always leads to extraction work in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state == ST_EMIT)
		else $error("word taken but controller not extracting");

	// A value that is not the last of its word keeps the controller extracting.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !st.last) |=> (state == ST_EMIT && !word_ch.ready || !st.out_free
			|| state == ST_EMIT))
		else $error("word left before its last value");

	// An extracted value shows up on the output in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |=> value_ch.valid)
		else $error("extracted value not presented");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the fixed-width bit unpacker: drives packed words,
// predicts every unpacked value and compares each value transfer in order.
// Depends on fbu_pkg, fbu_if and fixed_width_bit_unpacker from the RTL.
`timescale 1ns / 100ps

module tb_top;
	import fbu_pkg::*;

	localparam int BLOCK_VALUES = 1024;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 16;

	// Idle mixes for the two sides of the block.
	typedef enum int {
		IDLE_SEND_LIGHT,	// sender idles 23 percent of the time, receiver 51
		IDLE_RECV_LIGHT,	// sender idles 51 percent of the time, receiver 23
		IDLE_NONE		// both sides run flat out
	} idle_mix_t;

	// The scoreboard keeps its own copy of the width register and of the
	// bits carried between words, and queues the values each word must yield.
	class value_scoreboard #(int BLOCK_LEN = 1024);
		typedef struct {
			logic [WORD_W-1:0] value;
			logic block_last;
			logic run_last;
		} unpacked_t;

		logic [VBITS_W-1:0] width_reg;
		logic [LEFT_W-1:0] held_bits;
		logic [LCNT_W-1:0] held_count;
		int unsigned value_pos;
		unpacked_t expected_values[$];
		int unsigned fails;

		function new();
			fails = 0;
			restart(VBITS_RESET);
		endfunction

		// A write to the width register starts a fresh stream.
		function void restart(input logic [VBITS_W-1:0] vb);
			width_reg = vb;
			held_bits = '0;
			held_count = '0;
			value_pos = 0;
		endfunction

		function int pending();
			return expected_values.size();
		endfunction

		// Called for every accepted word: appends each value it completes.
		function void note_word(input logic [WORD_W-1:0] word);
			int unsigned wbits;
			int unsigned total;
			int n;
			logic [63:0] mask;
			logic [63:0] acc;
			unpacked_t u;
			if (width_reg == '0) begin
				wbits = 1;
			end else if (width_reg > 6'd32) begin
				wbits = 32;
			end else begin
				wbits = 32'(width_reg);
			end
			mask = (wbits >= 32) ? 64'h0000_0000_FFFF_FFFF : ((64'd1 << wbits) - 64'd1);
			acc = {33'd0, held_bits} | ({32'd0, word} << held_count);
			total = held_count + 32;
			n = 0;
			while (total >= wbits && n < 32) begin
				u.value = acc[31:0] & mask[31:0];
				u.block_last = (value_pos == BLOCK_LEN - 1);
				// The last value of a word is the one after which no further
				// complete value remains.
				u.run_last = ((total - wbits) < wbits) || (n == 31);
				expected_values.push_back(u);
				value_pos++;
				if (value_pos >= BLOCK_LEN) begin
					value_pos = 0;
				end
				acc = acc >> wbits;
				total = total - wbits;
				n++;
			end
			held_bits = acc[LEFT_W-1:0];
			held_count = total[LCNT_W-1:0];
		endfunction

		// Called for every accepted value transfer.
		function void check_value(input logic [WORD_W-1:0] value, input logic block_last,
				input logic run_last);
			unpacked_t u;
			if (expected_values.size() == 0) begin
				$display("%0t: value %h (block_last %b, run_last %b) with nothing expected",
					$time, value, block_last, run_last);
				fails++;
				return;
			end
			u = expected_values.pop_front();
			if (value !== u.value) begin
				$display("%0t: value expected %h actual %h", $time, u.value, value);
				fails++;
			end
			if (block_last !== u.block_last) begin
				$display("%0t: block_last expected %b actual %b", $time, u.block_last,
					block_last);
				fails++;
			end
			if (run_last !== u.run_last) begin
				$display("%0t: run_last expected %b actual %b", $time, u.run_last, run_last);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fbu_word_if word_ch();
	fbu_value_if value_ch();
	fbu_cfg_if cfg_ch();

	fixed_width_bit_unpacker #(
		.BLOCK_VALUES(BLOCK_VALUES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.word_ch(word_ch),
		.value_ch(value_ch),
		.cfg_ch(cfg_ch)
	);

	value_scoreboard #(BLOCK_VALUES) sb;

	// Idle percentages, set by the stimulus and read by both sides.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	// The stimulus raises this once; the receiver then holds ready low for a
	// long stretch so that the output register and the word channel back up.
	bit want_long_hold;
	bit long_hold_done;
	int unsigned hold_left;

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	// Watchdog: counts cycles and ends a run that hangs.
	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Receiver: checks each value transfer and then decides ready for the next
	// cycle. Signals are read right after the edge, so they hold the values
	// that the edge itself sampled.
	initial begin
		hold_left = 0;
		long_hold_done = 1'b0;
		value_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && value_ch.valid === 1'b1 && value_ch.ready === 1'b1) begin
				sb.check_value(value_ch.value, value_ch.block_last, value_ch.run_last);
			end
			if (hold_left > 0) begin
				hold_left--;
				value_ch.ready <= 1'b0;
			end else if (want_long_hold && !long_hold_done) begin
				hold_left = LONG_HOLD_CYCLES;
				long_hold_done = 1'b1;
				value_ch.ready <= 1'b0;
			end else begin
				value_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic set_idle(input idle_mix_t mix);
		case (mix)
			IDLE_SEND_LIGHT: begin
				send_idle_pct = 23;
				recv_idle_pct = 51;
			end
			IDLE_RECV_LIGHT: begin
				send_idle_pct = 51;
				recv_idle_pct = 23;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Offers one word, with a random gap in front of it, and returns at the
	// edge where the transfer happens. Valid stays high afterwards so that
	// back-to-back words can follow each other without a gap.
	task automatic send_word(input logic [WORD_W-1:0] word);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			word_ch.valid <= 1'b0;
			@(posedge clk);
		end
		word_ch.valid <= 1'b1;
		word_ch.packed_word <= word;
		do begin
			@(posedge clk);
		end while (word_ch.ready !== 1'b1);
		sb.note_word(word);
	endtask

	// Stops offering words and waits until every predicted value has arrived.
	// Each word yields at least one value, so the block is idle by then.
	task automatic wait_drained();
		word_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Writes the width register; only called once the block has drained.
	task automatic write_width(input logic [VBITS_W-1:0] vb);
		cfg_ch.valid <= 1'b1;
		cfg_ch.value_bits <= vb;
		do begin
			@(posedge clk);
		end while (cfg_ch.ready !== 1'b1);
		sb.restart(vb);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random words, with all-zero and all-one words mixed in now and then.
	function automatic logic [WORD_W-1:0] random_word();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return $urandom;
	endfunction

	initial begin
		logic [VBITS_W-1:0] phase_width[12];
		int phase_words[12];

		sb = new();
		want_long_hold = 1'b0;
		set_idle(IDLE_SEND_LIGHT);
		arst_n <= 1'b0;
		word_ch.valid <= 1'b0;
		word_ch.packed_word <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.value_bits <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The reset width of 16 comes first, with extreme words.
		send_word('0);
		send_word('1);
		send_word(32'hA5A5_A5A5);
		send_word(32'h1234_5678);

		// A width of zero behaves as one bit: 32 values per word.
		wait_drained();
		write_width(6'd0);
		send_word(32'h8000_0001);

		// The largest register value behaves as 32 bits, one value per word.
		wait_drained();
		write_width(6'd63);
		send_word('0);
		send_word('1);
		wait_drained();
		write_width(6'd33);
		send_word(32'hDEAD_BEEF);

		// Full 32-bit width.
		wait_drained();
		write_width(6'd32);
		send_word(32'h8000_0000);
		send_word(32'h0000_0001);

		// 31-bit values straddle each word boundary, with the carry growing.
		wait_drained();
		write_width(6'd31);
		send_word('1);
		send_word(32'h5555_5555);

		// Five-bit values leave two bits over after the first word. Writing the
		// same width again must throw those bits and the value count away.
		wait_drained();
		write_width(6'd5);
		send_word(32'hFFFF_FFFF);
		send_word(32'h0000_0000);
		send_word(32'hC000_0003);
		wait_drained();
		write_width(6'd5);
		send_word(32'h1357_9BDF);
		send_word(32'h2468_ACE0);

		// Random part: phases of different widths and idle mixes. The one-bit
		// and zero-width phases are long enough to cross a block boundary.
		phase_width = '{6'd1, 6'd32, 6'd3, 6'd17, 6'd31, 6'd0,
			6'd63, 6'd2, 6'd0, 6'd0, 6'd24, 6'd9};
		phase_words = '{40, 25, 25, 25, 25, 36, 20, 30, 25, 25, 25, 25};
		phase_width[8] = VBITS_W'($urandom_range(1, 32));
		phase_width[9] = VBITS_W'($urandom_range(1, 63));
		for (int p = 0; p < 12; p++) begin
			wait_drained();
			write_width(phase_width[p]);
			set_idle(idle_mix_t'(p % 3));
			// The 17-bit phase also carries the long receiver hold-off.
			if (phase_width[p] == 6'd17) begin
				want_long_hold = 1'b1;
			end
			for (int i = 0; i < phase_words[p]; i++) begin
				send_word(random_word());
			end
		end

		// Drain, give the block a few more cycles, then report.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[fixed_width_bit_unpacker.f]
rtl/core/fbu_pkg.sv
rtl/core/fbu_if.sv
rtl/core/fbu_dp.sv
rtl/core/fbu_ctrl.sv
rtl/core/fixed_width_bit_unpacker.sv
bench/tb_top.sv
